// File: rtl/core/lcs_pkg.sv
// Shared types, codes and constants of the link connection supervisor.
`timescale 1ns / 1ps
package lcs_pkg;

   // link phases
   localparam logic [2:0] PH_SCAN         = 3'd0;
   localparam logic [2:0] PH_CONNECTING   = 3'd1;
   localparam logic [2:0] PH_DISCOVER     = 3'd2;
   localparam logic [2:0] PH_SUBSCRIBE    = 3'd3;
   localparam logic [2:0] PH_CONNECTED    = 3'd4;
   localparam logic [2:0] PH_DISCONNECTED = 3'd5;

   // event codes
   localparam logic [2:0] OP_TICK       = 3'd0;
   localparam logic [2:0] OP_SEEN       = 3'd1;
   localparam logic [2:0] OP_LINK_UP    = 3'd2;
   localparam logic [2:0] OP_REJECTED   = 3'd3;
   localparam logic [2:0] OP_DISCOVERED = 3'd4;
   localparam logic [2:0] OP_SUBSCRIBED = 3'd5;
   localparam logic [2:0] OP_LINK_DOWN  = 3'd6;
   localparam logic [2:0] OP_NOTIFY     = 3'd7;

   // register indexes
   localparam logic [2:0] REG_TARGET_ADDRESS   = 3'd0;
   localparam logic [2:0] REG_MAX_ATTEMPTS     = 3'd1;
   localparam logic [2:0] REG_RETRY_DELAY      = 3'd2;
   localparam logic [2:0] REG_HR_TIMEOUT       = 3'd3;
   localparam logic [2:0] REG_CONNECT_TIMEOUT  = 3'd4;
   localparam logic [2:0] REG_DISCOVER_TIMEOUT = 3'd5;
   localparam logic [2:0] REG_SUBSCRIBE_TIMEOUT = 3'd6;
   localparam logic [2:0] REG_IDLE_TIMEOUT     = 3'd7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   // register reset values
   localparam logic [47:0] RST_TARGET_ADDRESS    = 48'd0;
   localparam logic [7:0]  RST_MAX_ATTEMPTS      = 8'd3;
   localparam logic [15:0] RST_RETRY_DELAY       = 16'd2000;
   localparam logic [15:0] RST_HR_TIMEOUT        = 16'd10000;
   localparam logic [15:0] RST_CONNECT_TIMEOUT   = 16'd10000;
   localparam logic [15:0] RST_DISCOVER_TIMEOUT  = 16'd5000;
   localparam logic [15:0] RST_SUBSCRIBE_TIMEOUT = 16'd3000;
   localparam logic [15:0] RST_IDLE_TIMEOUT      = 16'd8000;

   localparam logic [31:0] RESCAN_HOLDOFF_MS = 32'd1000;
   localparam logic [7:0]  ATTEMPT_LIMIT     = 8'd255;
   localparam logic [15:0] RATE_BLANK        = 16'd255;
   localparam int          FLAG_WIDE_BIT     = 0;

   localparam int CMD_DEPTH_DEFAULT = 2;
   localparam int RSP_DEPTH_DEFAULT = 2;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] now_ms;
      logic        scan_active;
      logic [47:0] device_address;
      logic        step_ok;
      logic [7:0]  payload_len;
      logic [7:0]  hr_flags;
      logic [7:0]  hr_low;
      logic [7:0]  hr_high;
   } req_type;

   typedef struct packed {
      logic [2:0]  link_state;
      logic [15:0] heart_rate;
      logic [7:0]  attempt_count;
      logic        restart_scan;
      logic        stop_scan;
      logic        open_link;
      logic        release_link;
      logic        discover_request;
      logic        subscribe_request;
   } rsp_type;

   typedef struct packed {
      logic [47:0] target_address;
      logic [7:0]  max_attempts;
      logic [15:0] retry_delay_ms;
      logic [15:0] hr_timeout_ms;
      logic [15:0] connect_timeout_ms;
      logic [15:0] discover_timeout_ms;
      logic [15:0] subscribe_timeout_ms;
      logic [15:0] idle_timeout_ms;
   } cfg_type;

   // classified event, as queued between front and back
   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] now_ms;
      logic        scan_active;
      logic        addr_match;
      logic        step_ok;
      logic        sample_update;
      logic        rate_load;
      logic [15:0] rate_next;
   } cmd_type;

   // queue handshake between front and back
   typedef struct packed {
      logic    empty;
      cmd_type item;
   } cmd_link_type;

endpackage

// File: rtl/core/lcs_front.sv
// Front end: accepts event words, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module lcs_front #(
   parameter int CMD_DEPTH = lcs_pkg::CMD_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  lcs_pkg::req_type      req_item,
   input  lcs_pkg::cfg_type      cfg,
   output lcs_pkg::cmd_link_type cmd_link,
   input  logic                  cmd_take
);
   import lcs_pkg::*;

   localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   cmd_type    queue_ff [CMD_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   cmd_type    classified;
   logic       do_push, do_pop;

   // state-independent part of the event: address match and notify parsing
   always_comb begin
      classified.operation     = req_item.operation;
      classified.now_ms        = req_item.now_ms;
      classified.scan_active   = req_item.scan_active;
      classified.step_ok       = req_item.step_ok;
      classified.addr_match    = (req_item.device_address == cfg.target_address);
      classified.sample_update = (req_item.operation == OP_NOTIFY) &&
                                 (req_item.payload_len != 8'd0);
      if (req_item.hr_flags[FLAG_WIDE_BIT]) begin
         classified.rate_load = classified.sample_update && (req_item.payload_len >= 8'd3);
         classified.rate_next = {req_item.hr_high, req_item.hr_low};
      end else begin
         classified.rate_load = classified.sample_update && (req_item.payload_len >= 8'd2);
         classified.rate_next = {8'd0, req_item.hr_low};
      end
   end

   assign req_full = (count_ff == CNT_W'(CMD_DEPTH));
   assign do_push  = req_push && !req_full;
   assign do_pop   = cmd_take && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

   assign cmd_link.empty = (count_ff == '0);
   assign cmd_link.item  = queue_ff[rd_ptr_ff];

endmodule

// File: rtl/core/lcs_back.sv
// Back end: link phase machine, timers and attempt counter, with the result queue.
`timescale 1ns / 1ps
module lcs_back #(
   parameter int RSP_DEPTH = lcs_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lcs_pkg::cfg_type      cfg,
   input  lcs_pkg::cmd_link_type cmd_link,
   output logic                  cmd_take,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output lcs_pkg::rsp_type      rsp_item
);
   import lcs_pkg::*;

   localparam int PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] entered_ff, entered_in;
   logic [31:0] last_attempt_ff, last_attempt_in;
   logic [31:0] last_sample_ff, last_sample_in;
   logic [7:0]  attempts_ff, attempts_in;
   logic        known_ff, known_in;
   logic        wanted_ff, wanted_in;
   logic [15:0] rate_ff, rate_in;

   rsp_type          rsp_queue_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   cmd_type     cmd;
   rsp_type     result;
   logic        fire, do_pop, do_fail;
   logic [31:0] since_sample, since_entry, since_attempt;
   logic [15:0] phase_limit;

   assign cmd           = cmd_link.item;
   assign since_sample  = cmd.now_ms - last_sample_ff;
   assign since_entry   = cmd.now_ms - entered_ff;
   assign since_attempt = cmd.now_ms - last_attempt_ff;

   always_comb begin
      priority case (phase_ff)
         PH_CONNECTING: phase_limit = cfg.connect_timeout_ms;
         PH_DISCOVER:   phase_limit = cfg.discover_timeout_ms;
         PH_SUBSCRIBE:  phase_limit = cfg.subscribe_timeout_ms;
         default:       phase_limit = cfg.idle_timeout_ms;
      endcase
   end

   // an event can end in a failure at most once; it is applied last
   always_comb begin
      phase_in        = phase_ff;
      entered_in      = entered_ff;
      last_attempt_in = last_attempt_ff;
      last_sample_in  = last_sample_ff;
      attempts_in     = attempts_ff;
      known_in        = known_ff;
      wanted_in       = wanted_ff;
      rate_in         = rate_ff;
      do_fail         = 1'b0;
      result          = '0;

      unique case (cmd.operation)
         OP_TICK: begin
            if (phase_ff == PH_CONNECTED) begin
               if (since_sample > {16'd0, cfg.hr_timeout_ms}) begin
                  do_fail = 1'b1;
               end
            end else if (phase_ff == PH_SCAN) begin
               if (!cmd.scan_active) begin
                  result.restart_scan = 1'b1;
               end
               if (wanted_ff && known_ff && (since_attempt >= {16'd0, cfg.retry_delay_ms})) begin
                  last_attempt_in = cmd.now_ms;
                  attempts_in = (attempts_ff != ATTEMPT_LIMIT) ? attempts_ff + 1'b1 : attempts_ff;
                  if (attempts_in > cfg.max_attempts) begin
                     do_fail = 1'b1;
                  end else begin
                     phase_in         = PH_CONNECTING;
                     result.open_link = 1'b1;
                  end
               end
            end else begin
               if (since_entry > {16'd0, phase_limit}) begin
                  do_fail = 1'b1;
               end else if (phase_ff == PH_DISCONNECTED && known_ff &&
                            since_attempt >= RESCAN_HOLDOFF_MS) begin
                  phase_in            = PH_SCAN;
                  result.restart_scan = 1'b1;
                  wanted_in           = 1'b1;
               end
            end
         end
         OP_SEEN: begin
            if (cmd.addr_match) begin
               result.stop_scan = 1'b1;
               known_in         = 1'b1;
               wanted_in        = 1'b1;
            end
         end
         OP_LINK_UP: begin
            if (phase_ff == PH_CONNECTING) begin
               phase_in                = PH_DISCOVER;
               result.discover_request = 1'b1;
            end
         end
         OP_REJECTED: begin
            if (phase_ff == PH_CONNECTING) begin
               do_fail = 1'b1;
            end
         end
         OP_DISCOVERED: begin
            if (phase_ff == PH_DISCOVER) begin
               if (cmd.step_ok) begin
                  phase_in                 = PH_SUBSCRIBE;
                  result.subscribe_request = 1'b1;
               end else begin
                  do_fail = 1'b1;
               end
            end
         end
         OP_SUBSCRIBED: begin
            if (phase_ff == PH_SUBSCRIBE) begin
               if (cmd.step_ok) begin
                  attempts_in    = '0;
                  last_sample_in = cmd.now_ms;
                  phase_in       = PH_CONNECTED;
               end else begin
                  do_fail = 1'b1;
               end
            end
         end
         OP_LINK_DOWN: begin
            attempts_in         = '0;
            result.release_link = 1'b1;
            phase_in            = PH_DISCONNECTED;
            last_attempt_in     = cmd.now_ms;
            if (known_ff) begin
               wanted_in = 1'b1;
            end
         end
         OP_NOTIFY: begin
            if (cmd.rate_load) begin
               rate_in = cmd.rate_next;
            end
            if (cmd.sample_update) begin
               last_sample_in = cmd.now_ms;
            end
         end
      endcase

      if (do_fail) begin
         result.release_link = 1'b1;
         wanted_in           = 1'b0;
         if (attempts_in >= cfg.max_attempts) begin
            // out of attempts: forget the target and rescan
            attempts_in         = '0;
            known_in            = 1'b0;
            phase_in            = PH_SCAN;
            result.restart_scan = 1'b1;
         end else begin
            phase_in        = PH_DISCONNECTED;
            last_attempt_in = cmd.now_ms;
         end
      end

      if (phase_in != phase_ff) begin
         entered_in = cmd.now_ms;
      end

      result.link_state    = phase_in;
      result.heart_rate    = (rate_in == RATE_BLANK) ? 16'd0 : rate_in;
      result.attempt_count = attempts_in;
   end

   assign do_pop   = rsp_pop && (count_ff != '0);
   assign fire     = !cmd_link.empty && ((count_ff != CNT_W'(RSP_DEPTH)) || do_pop);
   assign cmd_take = fire;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (fire && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_SCAN;
         entered_ff      <= '0;
         last_attempt_ff <= '0;
         last_sample_ff  <= '0;
         attempts_ff     <= '0;
         known_ff        <= 1'b0;
         wanted_ff       <= 1'b0;
         rate_ff         <= '0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         if (fire) begin
            phase_ff        <= phase_in;
            entered_ff      <= entered_in;
            last_attempt_ff <= last_attempt_in;
            last_sample_ff  <= last_sample_in;
            attempts_ff     <= attempts_in;
            known_ff        <= known_in;
            wanted_ff       <= wanted_in;
            rate_ff         <= rate_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_queue_ff[wr_ptr_ff] <= result;
      end
   end

   assign rsp_empty = (count_ff == '0);
   assign rsp_item  = rsp_queue_ff[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fire |-> (count_ff != CNT_W'(RSP_DEPTH)) || do_pop)
      else $error("result queue written while full");

   a_open_in_connecting: assert property (@(posedge clock) disable iff (reset)
      fire && result.open_link |=> phase_ff == PH_CONNECTING)
      else $error("open issued without entering connecting");

   a_drop_rescans: assert property (@(posedge clock) disable iff (reset)
      fire && do_fail && result.link_state == PH_SCAN |-> result.restart_scan && !known_in)
      else $error("target drop without rescan");

   a_fail_releases: assert property (@(posedge clock) disable iff (reset)
      fire && do_fail |=> !wanted_ff)
      else $error("failure left a connect pending");

endmodule

// File: rtl/core/link_connection_supervisor.sv
// Top level of the link connection supervisor: register file and front/back hookup.
//
// Usage: events enter on the req_ queue port (req_push, req_full, req_item), one word
// per event with its millisecond stamp. Every event yields exactly one result word on
// the rsp_ queue port (rsp_empty, rsp_pop, rsp_item): the link phase after the event,
// the stored heart rate, the attempt count and the radio command flags it issued.
// Registers are written through csr_we / csr_index / csr_wdata, one per cycle, with
// effect from the next cycle; write them only while no events are in flight.
// A pushed word is classified and registered in the command queue; the phase machine then
// runs it when the result queue has room or is being popped, and registers its result word
// in the result queue, from which it shows on rsp_item and can be popped.
// Throughput: one event per cycle while the receiver keeps popping, set by the back end's phase update.
// When the receiver stops popping, the result queue fills, the back end stops taking
// commands, the command queue fills and req_full rises; nothing is dropped.
// Reset (synchronous, active high) empties both queues, restores register defaults
// and returns the link to scanning with all timers and counters cleared.
`timescale 1ns / 1ps
module link_connection_supervisor #(
   parameter int CMD_DEPTH = lcs_pkg::CMD_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = lcs_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  lcs_pkg::req_type                req_item,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output lcs_pkg::rsp_type                rsp_item,
   input  logic                            csr_we,
   input  logic [lcs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lcs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lcs_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   cmd_link_type cmd_link;
   logic         cmd_take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_TARGET_ADDRESS:    cfg_in.target_address       = csr_wdata[47:0];
            REG_MAX_ATTEMPTS:      cfg_in.max_attempts         = csr_wdata[7:0];
            REG_RETRY_DELAY:       cfg_in.retry_delay_ms       = csr_wdata[15:0];
            REG_HR_TIMEOUT:        cfg_in.hr_timeout_ms        = csr_wdata[15:0];
            REG_CONNECT_TIMEOUT:   cfg_in.connect_timeout_ms   = csr_wdata[15:0];
            REG_DISCOVER_TIMEOUT:  cfg_in.discover_timeout_ms  = csr_wdata[15:0];
            REG_SUBSCRIBE_TIMEOUT: cfg_in.subscribe_timeout_ms = csr_wdata[15:0];
            REG_IDLE_TIMEOUT:      cfg_in.idle_timeout_ms      = csr_wdata[15:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_address       <= RST_TARGET_ADDRESS;
         cfg_ff.max_attempts         <= RST_MAX_ATTEMPTS;
         cfg_ff.retry_delay_ms       <= RST_RETRY_DELAY;
         cfg_ff.hr_timeout_ms        <= RST_HR_TIMEOUT;
         cfg_ff.connect_timeout_ms   <= RST_CONNECT_TIMEOUT;
         cfg_ff.discover_timeout_ms  <= RST_DISCOVER_TIMEOUT;
         cfg_ff.subscribe_timeout_ms <= RST_SUBSCRIBE_TIMEOUT;
         cfg_ff.idle_timeout_ms      <= RST_IDLE_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcs_front #(
      .CMD_DEPTH (CMD_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .cfg      (cfg_ff),
      .cmd_link (cmd_link),
      .cmd_take (cmd_take)
   );

   lcs_back #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_link  (cmd_link),
      .cmd_take  (cmd_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

// File: dv/link_connection_supervisor_tb.sv
// Self-checking testbench for the link connection supervisor: event words in, result words checked.
`timescale 1ns / 1ps
module link_connection_supervisor_tb;
   import lcs_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 60;
   localparam int MAX_REPORTS = 40;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   req_type                req_item = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   rsp_type                rsp_item;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   rsp_type     pending_results[$];
   int          mismatches = 0;
   int          events_sent = 0;
   int          results_checked = 0;
   int          send_gap_pct = 0;
   int          recv_gap_pct = 0;
   int          hold_requests = 0;
   int          hold_served = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   int unsigned step_scale = 1000;
   logic [31:0] clock_ms = '0;

   // supervisor model state
   cfg_type     cfg_model;
   logic [2:0]  link_phase = PH_SCAN;
   logic [31:0] phase_since = '0;
   logic [31:0] last_try_at = '0;
   logic [31:0] last_hr_at = '0;
   logic [7:0]  tries = '0;
   logic        have_target = 1'b0;
   logic        want_connect = 1'b0;
   logic [15:0] hr_value = '0;
   rsp_type     link_cmds;

   link_connection_supervisor i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void move_to(logic [2:0] next_phase, logic [31:0] now);
      if (link_phase != next_phase) begin
         link_phase  = next_phase;
         phase_since = now;
      end
   endfunction

   function automatic void drop_link(logic [31:0] now);
      link_cmds.release_link = 1'b1;
      want_connect = 1'b0;
      if (tries >= cfg_model.max_attempts) begin
         tries       = '0;
         have_target = 1'b0;
         move_to(PH_SCAN, now);
         link_cmds.restart_scan = 1'b1;
      end else begin
         move_to(PH_DISCONNECTED, now);
         last_try_at = now;
      end
   endfunction

   function automatic rsp_type supervise_event(req_type ev);
      logic [31:0] now;
      logic [31:0] limit;
      logic        timed_out;
      rsp_type     result;
      now       = ev.now_ms;
      timed_out = 1'b0;
      link_cmds = '0;
      case (ev.operation)
         OP_TICK: begin
            if (link_phase == PH_CONNECTED &&
                32'(now - last_hr_at) > {16'd0, cfg_model.hr_timeout_ms}) begin
               drop_link(now);
            end
            if (link_phase != PH_SCAN && link_phase != PH_CONNECTED) begin
               case (link_phase)
                  PH_CONNECTING: limit = {16'd0, cfg_model.connect_timeout_ms};
                  PH_DISCOVER:   limit = {16'd0, cfg_model.discover_timeout_ms};
                  PH_SUBSCRIBE:  limit = {16'd0, cfg_model.subscribe_timeout_ms};
                  default:       limit = {16'd0, cfg_model.idle_timeout_ms};
               endcase
               if (32'(now - phase_since) > limit) begin
                  drop_link(now);
                  timed_out = 1'b1;
               end
            end
            if (!timed_out && link_phase == PH_SCAN) begin
               if (!ev.scan_active) begin
                  link_cmds.restart_scan = 1'b1;
               end
               if (want_connect && have_target &&
                   32'(now - last_try_at) >= {16'd0, cfg_model.retry_delay_ms}) begin
                  last_try_at = now;
                  if (tries != ATTEMPT_LIMIT) begin
                     tries++;
                  end
                  if (tries > cfg_model.max_attempts) begin
                     drop_link(now);
                  end else begin
                     move_to(PH_CONNECTING, now);
                     link_cmds.open_link = 1'b1;
                  end
               end
            end else if (!timed_out && link_phase == PH_DISCONNECTED && have_target &&
                         32'(now - last_try_at) >= RESCAN_HOLDOFF_MS) begin
               move_to(PH_SCAN, now);
               link_cmds.restart_scan = 1'b1;
               want_connect = 1'b1;
            end
         end
         OP_SEEN: begin
            if (ev.device_address == cfg_model.target_address) begin
               link_cmds.stop_scan = 1'b1;
               have_target  = 1'b1;
               want_connect = 1'b1;
            end
         end
         OP_LINK_UP: begin
            if (link_phase == PH_CONNECTING) begin
               move_to(PH_DISCOVER, now);
               link_cmds.discover_request = 1'b1;
            end
         end
         OP_REJECTED: begin
            if (link_phase == PH_CONNECTING) begin
               drop_link(now);
            end
         end
         OP_DISCOVERED: begin
            if (link_phase == PH_DISCOVER) begin
               if (ev.step_ok) begin
                  move_to(PH_SUBSCRIBE, now);
                  link_cmds.subscribe_request = 1'b1;
               end else begin
                  drop_link(now);
               end
            end
         end
         OP_SUBSCRIBED: begin
            if (link_phase == PH_SUBSCRIBE) begin
               if (ev.step_ok) begin
                  tries      = '0;
                  last_hr_at = now;
                  move_to(PH_CONNECTED, now);
               end else begin
                  drop_link(now);
               end
            end
         end
         OP_LINK_DOWN: begin
            tries = '0;
            link_cmds.release_link = 1'b1;
            move_to(PH_DISCONNECTED, now);
            last_try_at = now;
            if (have_target) begin
               want_connect = 1'b1;
            end
         end
         OP_NOTIFY: begin
            // short payloads keep the rate but still count as a sign of life
            if (ev.payload_len != 8'd0) begin
               if (!ev.hr_flags[FLAG_WIDE_BIT]) begin
                  if (ev.payload_len >= 8'd2) begin
                     hr_value = {8'd0, ev.hr_low};
                  end
               end else if (ev.payload_len >= 8'd3) begin
                  hr_value = {ev.hr_high, ev.hr_low};
               end
               last_hr_at = now;
            end
         end
         default: ;
      endcase
      result               = link_cmds;
      result.link_state    = link_phase;
      result.heart_rate    = (hr_value == RATE_BLANK) ? 16'd0 : hr_value;
      result.attempt_count = tries;
      return result;
   endfunction

   // event stamped step ms after the previous one, unused fields random
   function automatic req_type event_at(logic [2:0] op, int unsigned step);
      req_type ev;
      clock_ms          = clock_ms + step;
      ev.operation      = op;
      ev.now_ms         = clock_ms;
      ev.scan_active    = 1'($urandom);
      ev.device_address = {16'($urandom), $urandom};
      ev.step_ok        = 1'($urandom);
      ev.payload_len    = 8'($urandom);
      ev.hr_flags       = 8'($urandom);
      ev.hr_low         = 8'($urandom);
      ev.hr_high        = 8'($urandom);
      return ev;
   endfunction

   // mostly the event that moves the current phase on, some noise
   function automatic req_type pick_event();
      req_type     ev;
      int unsigned step;
      int unsigned roll;
      int unsigned pick;
      roll = $urandom_range(99);
      if (roll < 45) step = $urandom_range(step_scale / 4);
      else if (roll < 94) step = $urandom_range(step_scale * 2);
      else if (roll < 97) step = $urandom;
      else step = 0;
      ev   = event_at(OP_TICK, step);
      roll = $urandom_range(99);
      pick = $urandom_range(99);
      if (roll < 15) begin
         ev.operation = 3'($urandom);
         if (pick < 50) begin
            ev.device_address = cfg_model.target_address;
         end
         return ev;
      end
      ev.step_ok = ($urandom_range(99) < 80);
      case (link_phase)
         PH_SCAN: begin
            if (!have_target || roll < 30) begin
               ev.operation = OP_SEEN;
               if (pick < 75) begin
                  ev.device_address = cfg_model.target_address;
               end
            end
         end
         PH_CONNECTING: begin
            if (roll < 60) ev.operation = OP_LINK_UP;
            else if (roll < 75) ev.operation = OP_REJECTED;
         end
         PH_DISCOVER: begin
            if (roll < 70) ev.operation = OP_DISCOVERED;
         end
         PH_SUBSCRIBE: begin
            if (roll < 70) ev.operation = OP_SUBSCRIBED;
         end
         PH_CONNECTED: begin
            if (roll < 65) begin
               ev.operation = OP_NOTIFY;
               if (pick < 75) begin
                  ev.payload_len = 8'($urandom_range(4));
               end
            end else if (roll < 88) begin
               ev.operation = OP_TICK;
            end else if (roll < 94) begin
               ev.operation = OP_LINK_DOWN;
            end else begin
               ev.operation      = OP_SEEN;
               ev.device_address = cfg_model.target_address;
            end
         end
         default: begin
            if (roll > 93) ev.operation = OP_LINK_DOWN;
         end
      endcase
      return ev;
   endfunction

   task automatic send_event(req_type ev);
      int gap;
      if ($urandom_range(99) < send_gap_pct) begin
         req_push <= 1'b0;
         gap = $urandom_range(4, 1);
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= ev;
      do @(posedge clock); while (req_full);
      pending_results.push_back(supervise_event(ev));
      events_sent++;
   endtask

   task automatic settle();
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic load_settings(cfg_type s);
      logic [CSR_DATA_W-1:0] value;
      settle();
      for (int idx = 0; idx < 8; idx++) begin
         case (3'(idx))
            REG_TARGET_ADDRESS:    value = s.target_address;
            REG_MAX_ATTEMPTS:      value = {40'd0, s.max_attempts};
            REG_RETRY_DELAY:       value = {32'd0, s.retry_delay_ms};
            REG_HR_TIMEOUT:        value = {32'd0, s.hr_timeout_ms};
            REG_CONNECT_TIMEOUT:   value = {32'd0, s.connect_timeout_ms};
            REG_DISCOVER_TIMEOUT:  value = {32'd0, s.discover_timeout_ms};
            REG_SUBSCRIBE_TIMEOUT: value = {32'd0, s.subscribe_timeout_ms};
            default:               value = {32'd0, s.idle_timeout_ms};
         endcase
         csr_we    <= 1'b1;
         csr_index <= 3'(idx);
         csr_wdata <= value;
         @(posedge clock);
      end
      csr_we    <= 1'b0;
      cfg_model = s;
   endtask

   // reset settings: full session, every rate format, watchdog, rescan, time wrap
   task automatic test_directed_walk();
      req_type ev;
      send_gap_pct = 36;
      recv_gap_pct = 51;
      clock_ms     = 32'hFFFF_F000;
      ev = event_at(OP_TICK, 0);
      ev.scan_active = 1'b0;
      send_event(ev);
      ev = event_at(OP_TICK, 5);
      ev.scan_active = 1'b1;
      send_event(ev);
      send_event(event_at(OP_LINK_UP, 1));
      send_event(event_at(OP_REJECTED, 1));
      ev = event_at(OP_DISCOVERED, 1);
      ev.step_ok = 1'b1;
      send_event(ev);
      ev = event_at(OP_SUBSCRIBED, 1);
      ev.step_ok = 1'b1;
      send_event(ev);
      ev = event_at(OP_SEEN, 1);
      ev.device_address = '1;
      send_event(ev);
      ev = event_at(OP_SEEN, 1);
      ev.device_address = '0;
      send_event(ev);
      ev = event_at(OP_TICK, 2000);
      ev.scan_active = 1'b1;
      send_event(ev);
      send_event(event_at(OP_LINK_UP, 10));
      ev = event_at(OP_DISCOVERED, 10);
      ev.step_ok = 1'b1;
      send_event(ev);
      ev = event_at(OP_SUBSCRIBED, 10);
      ev.step_ok = 1'b1;
      send_event(ev);
      ev = event_at(OP_NOTIFY, 1);
      ev.payload_len = 8'd0;
      send_event(ev);
      ev = event_at(OP_NOTIFY, 1);
      ev.payload_len = 8'd1;
      ev.hr_flags    = 8'h00;
      send_event(ev);
      ev = event_at(OP_NOTIFY, 1);
      ev.payload_len = 8'd2;
      ev.hr_flags    = 8'h00;
      ev.hr_low      = 8'hFF;
      send_event(ev);
      ev = event_at(OP_NOTIFY, 1);
      ev.payload_len = 8'd2;
      ev.hr_flags    = 8'h01;
      send_event(ev);
      ev = event_at(OP_NOTIFY, 1);
      ev.payload_len = 8'd3;
      ev.hr_flags    = 8'hFF;
      ev.hr_low      = 8'hFF;
      ev.hr_high     = 8'hFF;
      send_event(ev);
      ev = event_at(OP_NOTIFY, 1);
      ev.payload_len = 8'hFF;
      ev.hr_flags    = 8'hFE;
      ev.hr_low      = 8'h00;
      send_event(ev);
      ev = event_at(OP_TICK, 10001);
      ev.scan_active = 1'b1;
      send_event(ev);
      ev = event_at(OP_TICK, 1000);
      ev.scan_active = 1'b1;
      send_event(ev);
      ev = event_at(OP_TICK, 2000);
      ev.scan_active = 1'b1;
      send_event(ev);
      send_event(event_at(OP_REJECTED, 5));
      send_event(event_at(OP_LINK_DOWN, 5));
   endtask

   task automatic test_tight_timeouts();
      load_settings('{target_address: {16'($urandom), $urandom}, max_attempts: 8'd1,
                      retry_delay_ms: 16'd0, hr_timeout_ms: 16'd500,
                      connect_timeout_ms: 16'd300, discover_timeout_ms: 16'd200,
                      subscribe_timeout_ms: 16'd200, idle_timeout_ms: 16'd400});
      step_scale = 400;
      repeat (150) send_event(pick_event());
   endtask

   task automatic test_wide_settings();
      send_gap_pct = 51;
      recv_gap_pct = 36;
      load_settings('{target_address: '1, max_attempts: 8'd255,
                      retry_delay_ms: 16'hFFFF, hr_timeout_ms: 16'hFFFF,
                      connect_timeout_ms: 16'hFFFF, discover_timeout_ms: 16'hFFFF,
                      subscribe_timeout_ms: 16'hFFFF, idle_timeout_ms: 16'hFFFF});
      step_scale = 60000;
      repeat (120) send_event(pick_event());
   endtask

   // no attempt allowed: every connect drops the target at once
   task automatic test_zero_limits();
      send_gap_pct = 0;
      recv_gap_pct = 0;
      load_settings('{target_address: {16'($urandom), $urandom}, max_attempts: 8'd0,
                      retry_delay_ms: 16'd0, hr_timeout_ms: 16'd0,
                      connect_timeout_ms: 16'd0, discover_timeout_ms: 16'd0,
                      subscribe_timeout_ms: 16'd0, idle_timeout_ms: 16'd0});
      step_scale = 20;
      repeat (60) send_event(pick_event());
   endtask

   // receiver stops popping while events keep coming, so req_full must rise
   task automatic test_result_stall();
      load_settings('{target_address: {16'($urandom), $urandom},
                      max_attempts: 8'($urandom_range(5, 1)),
                      retry_delay_ms: 16'($urandom_range(2000, 100)),
                      hr_timeout_ms: 16'($urandom_range(3000, 200)),
                      connect_timeout_ms: 16'($urandom_range(3000, 200)),
                      discover_timeout_ms: 16'($urandom_range(3000, 200)),
                      subscribe_timeout_ms: 16'($urandom_range(3000, 200)),
                      idle_timeout_ms: 16'($urandom_range(3000, 200))});
      step_scale = 1500;
      hold_requests++;
      repeat (100) send_event(pick_event());
   endtask

   function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $error("%s: expected %0d, got %0d", name, want, got);
         end
      end
   endfunction

   always @(posedge clock) begin : result_side
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $error("result word %h with no event pending", rsp_item);
            end
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            compare_field("link_state", 16'(want.link_state), 16'(rsp_item.link_state));
            compare_field("heart_rate", want.heart_rate, rsp_item.heart_rate);
            compare_field("attempt_count", 16'(want.attempt_count),
                          16'(rsp_item.attempt_count));
            compare_field("restart_scan", 16'(want.restart_scan),
                          16'(rsp_item.restart_scan));
            compare_field("stop_scan", 16'(want.stop_scan), 16'(rsp_item.stop_scan));
            compare_field("open_link", 16'(want.open_link), 16'(rsp_item.open_link));
            compare_field("release_link", 16'(want.release_link),
                          16'(rsp_item.release_link));
            compare_field("discover_request", 16'(want.discover_request),
                          16'(rsp_item.discover_request));
            compare_field("subscribe_request", 16'(want.subscribe_request),
                          16'(rsp_item.subscribe_request));
         end
      end
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no word moved for %0d cycles, %0d results outstanding",
                  quiet_cycles, pending_results.size());
         $display("link_connection_supervisor_tb NOT OK");
         $finish;
      end
   end

   initial begin
      cfg_model = '{target_address: RST_TARGET_ADDRESS, max_attempts: RST_MAX_ATTEMPTS,
                    retry_delay_ms: RST_RETRY_DELAY, hr_timeout_ms: RST_HR_TIMEOUT,
                    connect_timeout_ms: RST_CONNECT_TIMEOUT,
                    discover_timeout_ms: RST_DISCOVER_TIMEOUT,
                    subscribe_timeout_ms: RST_SUBSCRIBE_TIMEOUT,
                    idle_timeout_ms: RST_IDLE_TIMEOUT};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_walk();
      test_tight_timeouts();
      test_wide_settings();
      test_zero_limits();
      test_result_stall();
      settle();
      repeat (8) @(posedge clock);
      $display("%0d events under five register settings, %0d results checked, %0d mismatches",
               events_sent, results_checked, mismatches);
      $display("covered: full sessions, every timeout, attempt limits 0/1/255, %0d-cycle stall",
               HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("link_connection_supervisor_tb OK");
      end else begin
         $display("link_connection_supervisor_tb NOT OK");
      end
      $finish;
   end

endmodule
